@@ rtl/tccs_pkg.sv @@
// shared types and constants for the text character class statistics unit
package tccs_pkg;

  localparam int unsigned LETTERS    = 26;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned OUT_DATA_W = 232;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = 2;

  localparam logic [IDX_W-1:0] LAST_LETTER = 5'd25;

  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;

  // classified word handed from front to back
  typedef struct packed {
    logic             last;
    logic             lower;
    logic             upper;
    logic             digit;
    logic             space;
    logic             newline;
    logic [IDX_W-1:0] letter;
  } cls_t;

endpackage

@@ rtl/tccs_front.sv @@
// input side: byte classifier and a short queue toward the counting back end
module tccs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  output logic                q_valid,
  output tccs_pkg::cls_t      q_item,
  input  logic                q_ready
);

  tccs_pkg::cls_t                  cls;
  tccs_pkg::cls_t                  store_r [tccs_pkg::QDEPTH];
  logic [tccs_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [tccs_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [tccs_pkg::QPTR_W:0]       cnt_r, cnt_nxt;
  logic [7:0]                      diff_low;
  logic [7:0]                      diff_up;
  logic                            push;
  logic                            pop;

  assign diff_low = in_tdata - tccs_pkg::CH_LOW_A;
  assign diff_up  = in_tdata - tccs_pkg::CH_UP_A;

  always_comb begin
    cls      = '0;
    cls.last = in_tlast;
    if (in_tdata >= tccs_pkg::CH_LOW_A && in_tdata <= tccs_pkg::CH_LOW_Z) begin
      cls.lower  = 1'b1;
      cls.letter = diff_low[tccs_pkg::IDX_W-1:0];
    end else if (in_tdata >= tccs_pkg::CH_UP_A && in_tdata <= tccs_pkg::CH_UP_Z) begin
      cls.upper  = 1'b1;
      cls.letter = diff_up[tccs_pkg::IDX_W-1:0];
    end else if (in_tdata >= tccs_pkg::CH_ZERO && in_tdata <= tccs_pkg::CH_NINE) begin
      cls.digit = 1'b1;
    end else if (in_tdata == tccs_pkg::CH_LF) begin
      cls.space   = 1'b1;
      cls.newline = 1'b1;
    end else if (in_tdata == tccs_pkg::CH_SPACE || in_tdata == tccs_pkg::CH_TAB ||
                 in_tdata == tccs_pkg::CH_VT || in_tdata == tccs_pkg::CH_FF ||
                 in_tdata == tccs_pkg::CH_CR) begin
      cls.space = 1'b1;
    end
  end

  assign in_tready = (cnt_r != (tccs_pkg::QPTR_W + 1)'(tccs_pkg::QDEPTH));
  assign q_valid   = (cnt_r != '0);
  assign q_item    = store_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= cls;
    end
  end

endmodule

@@ rtl/tccs_back.sv @@
// counting side: saturating totals, letter histogram and the 26-word report
module tccs_back #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  tccs_pkg::cls_t                      q_item,
  output logic                                q_ready,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tccs_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);

  typedef enum logic [1:0] {
    ST_COUNT  = 2'b01,
    ST_REPORT = 2'b10
  } state_t;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  state_t                          state_r, state_nxt;
  logic [tccs_pkg::IDX_W-1:0]      idx_r;
  logic [COUNT_WIDTH-1:0]          byte_r, lower_r, upper_r, digit_r, space_r, newline_r;
  logic [COUNT_WIDTH-1:0]          hist_r [tccs_pkg::LETTERS];
  logic                            last_nl_r;
  logic [tccs_pkg::IDX_W-1:0]      hist_addr;
  logic [COUNT_WIDTH-1:0]          hist_rd;
  logic [COUNT_WIDTH-1:0]          line_cnt;
  logic                            pop;
  logic                            slot_free;
  logic                            emit;
  logic                            report_done;
  logic                            out_valid_r;
  logic [tccs_pkg::IDX_W-1:0]      o_idx_r;
  logic [tccs_pkg::FIELD_W-1:0]    o_letter_r, o_byte_r, o_lower_r, o_upper_r;
  logic [tccs_pkg::FIELD_W-1:0]    o_digit_r, o_space_r, o_line_r;
  logic                            o_last_r;

  assign q_ready     = (state_r == ST_COUNT);
  assign pop         = q_valid && q_ready;
  assign slot_free   = !out_valid_r || out_tready;
  assign emit        = (state_r == ST_REPORT) && slot_free;
  assign report_done = emit && (idx_r == tccs_pkg::LAST_LETTER);

  // one histogram read port, shared by update and report
  assign hist_addr = (state_r == ST_REPORT) ? idx_r : q_item.letter;
  assign hist_rd   = hist_r[hist_addr];
  assign line_cnt  = last_nl_r ? newline_r : sat_inc(newline_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COUNT: begin
        if (pop && q_item.last) begin
          state_nxt = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (report_done) begin
          state_nxt = ST_COUNT;
        end
      end
      default: state_nxt = ST_COUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COUNT;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      byte_r      <= '0;
      lower_r     <= '0;
      upper_r     <= '0;
      digit_r     <= '0;
      space_r     <= '0;
      newline_r   <= '0;
      last_nl_r   <= 1'b0;
      for (int i = 0; i < tccs_pkg::LETTERS; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
        idx_r       <= idx_r + 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        idx_r     <= '0;
        byte_r    <= sat_inc(byte_r);
        last_nl_r <= q_item.newline;
        if (q_item.lower) begin
          lower_r <= sat_inc(lower_r);
        end
        if (q_item.upper) begin
          upper_r <= sat_inc(upper_r);
        end
        if (q_item.lower || q_item.upper) begin
          hist_r[q_item.letter] <= sat_inc(hist_rd);
        end
        if (q_item.digit) begin
          digit_r <= sat_inc(digit_r);
        end
        if (q_item.space) begin
          space_r <= sat_inc(space_r);
        end
        if (q_item.newline) begin
          newline_r <= sat_inc(newline_r);
        end
      end
      if (report_done) begin
        byte_r    <= '0;
        lower_r   <= '0;
        upper_r   <= '0;
        digit_r   <= '0;
        space_r   <= '0;
        newline_r <= '0;
        last_nl_r <= 1'b0;
        for (int i = 0; i < tccs_pkg::LETTERS; i++) begin
          hist_r[i] <= '0;
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (emit) begin
      o_idx_r    <= idx_r;
      o_letter_r <= tccs_pkg::FIELD_W'(hist_rd);
      o_byte_r   <= tccs_pkg::FIELD_W'(byte_r);
      o_lower_r  <= tccs_pkg::FIELD_W'(lower_r);
      o_upper_r  <= tccs_pkg::FIELD_W'(upper_r);
      o_digit_r  <= tccs_pkg::FIELD_W'(digit_r);
      o_space_r  <= tccs_pkg::FIELD_W'(space_r);
      o_line_r   <= tccs_pkg::FIELD_W'(line_cnt);
      o_last_r   <= (idx_r == tccs_pkg::LAST_LETTER);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {3'b000, o_line_r, o_space_r, o_digit_r, o_upper_r, o_lower_r,
                       o_byte_r, o_letter_r, o_idx_r};

endmodule

@@ rtl/text_character_class_statistics_unit.sv @@
// top level of the text character class statistics unit
//
//   channel | dir | tdata                                  | tlast
//   in_     | in  | [7:0] data_byte                        | end_of_text
//   out_    | out | letter_index, counts, see port comment | last_in_run
//
// one input word per cycle while counting; the classifier queue holds four words
// an end-of-text word is counted, then 26 report words leave at up to one per cycle
// during the report the counter stage takes no word, the queue keeps filling
// all counts clear after the word for letter z is loaded
// reset clears counters, histogram, queue and state machine
module text_character_class_statistics_unit #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [4:0] letter_index, [36:5] letter_count, [68:37] byte_count,
  // [100:69] lowercase_count, [132:101] uppercase_count, [164:133] digit_count,
  // [196:165] whitespace_count, [228:197] line_count, [231:229] zero
  output logic [231:0] out_tdata,
  output logic         out_tlast
);

  logic           q_valid;
  logic           q_ready;
  tccs_pkg::cls_t q_item;

  tccs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready)
  );

  tccs_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_ready    (q_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
